// ===== design/apc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the alpha premultiply converter
// used by every module and by the channel interfaces; no dependencies

package apc_pkg;

   localparam int PIXEL_W     = 32;
   localparam int CHAN_W      = 8;
   localparam int NUM_COLORS  = 3;
   localparam int ALPHA_LSB   = NUM_COLORS * CHAN_W;
   // quotient bits resolved in each divider stage
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = CHAN_W / DIV_STEPS;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   typedef enum logic {
      MODE_PREMULTIPLY   = 1'b0,
      MODE_UNPREMULTIPLY = 1'b1
   } mode_type;

   // restoring division state of one color channel
   typedef struct packed {
      logic [CHAN_W-1:0] rem;
      logic [CHAN_W-1:0] low;
      logic [CHAN_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]                     pixel;
      mode_type                               mode;
      logic [NUM_COLORS-1:0]                  sat;
      logic [NUM_COLORS-1:0][CHAN_W-1:0]      prem;
      div_type [NUM_COLORS-1:0]               div;
   } item_type;

endpackage

`default_nettype wire

// ===== design/apc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// input pixel channel: valid, ready and the pixel payload
// depends on apc_pkg for the pixel width

interface apc_req_if;
   logic                        valid;
   logic                        ready;
   logic [apc_pkg::PIXEL_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

// ===== design/apc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result pixel channel: valid, ready and the converted pixel payload
// depends on apc_pkg for the pixel width

interface apc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [apc_pkg::PIXEL_W-1:0] pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

// ===== design/apc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// first pipeline stage: splits the pixel, forms color*alpha products,
// the dividends color*255 and the saturation flags; depends on apc_pkg

module apc_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire logic [apc_pkg::PIXEL_W-1:0] in_pixel,
   input  wire apc_pkg::mode_type           in_mode,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      apc_pkg::item_type           out_item
);
   import apc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   always_comb begin
      item_in       = '0;
      item_in.pixel = in_pixel;
      item_in.mode  = in_mode;
      for (int i = 0; i < NUM_COLORS; i++) begin : chan
         logic [CHAN_W-1:0]   c;
         logic [CHAN_W-1:0]   a;
         logic [2*CHAN_W-1:0] prod;
         logic [2*CHAN_W-1:0] n;
         c    = in_pixel[i*CHAN_W +: CHAN_W];
         a    = in_pixel[ALPHA_LSB +: CHAN_W];
         prod = {{CHAN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, a};
         // color*255 as color*256 - color
         n    = {c, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, c};
         item_in.prem[i]    = prod[2*CHAN_W-1:CHAN_W];
         item_in.sat[i]     = (c >= a);
         item_in.div[i].rem = n[2*CHAN_W-1:CHAN_W];
         item_in.div[i].low = n[CHAN_W-1:0];
         item_in.div[i].quo = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== design/apc_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one divider stage: resolves DIV_STEPS quotient bits of color*255/alpha
// for all color channels by restoring compare and subtract; depends on apc_pkg

module apc_div_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire apc_pkg::item_type in_item,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      apc_pkg::item_type out_item
);
   import apc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   always_comb begin
      item_in = in_item;
      for (int i = 0; i < NUM_COLORS; i++) begin : chan
         logic [CHAN_W-1:0] a;
         logic [CHAN_W:0]   trial;
         div_type           d;
         a = in_item.pixel[ALPHA_LSB +: CHAN_W];
         d = in_item.div[i];
         for (int s = 0; s < DIV_STEPS; s++) begin
            // remainder stays below alpha, so the trial fits one extra bit
            trial = {d.rem, d.low[CHAN_W-1]};
            d.low = {d.low[CHAN_W-2:0], 1'b0};
            if (trial >= {1'b0, a}) begin
               trial = trial - {1'b0, a};
               d.quo = {d.quo[CHAN_W-2:0], 1'b1};
            end else begin
               d.quo = {d.quo[CHAN_W-2:0], 1'b0};
            end
            d.rem = trial[CHAN_W-1:0];
         end
         item_in.div[i] = d;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== design/apc_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// last pipeline stage: picks product, quotient or saturated value per color,
// handles zero alpha and holds the output register; depends on apc_pkg

module apc_pack (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output      logic                        in_ready,
   input  wire apc_pkg::item_type           in_item,
   output      logic                        out_valid,
   input  wire logic                        out_ready,
   output      logic [apc_pkg::PIXEL_W-1:0] out_pixel
);
   import apc_pkg::*;

   logic               valid_ff, valid_in;
   logic [PIXEL_W-1:0] pixel_ff, pixel_in;
   logic [CHAN_W-1:0]  alpha;
   logic               alpha_zero;

   assign alpha      = in_item.pixel[ALPHA_LSB +: CHAN_W];
   assign alpha_zero = (alpha == '0);

   always_comb begin
      pixel_in = '0;
      pixel_in[ALPHA_LSB +: CHAN_W] = alpha;
      for (int i = 0; i < NUM_COLORS; i++) begin
         unique case (in_item.mode)
            MODE_PREMULTIPLY:   pixel_in[i*CHAN_W +: CHAN_W] = in_item.prem[i];
            MODE_UNPREMULTIPLY: pixel_in[i*CHAN_W +: CHAN_W] =
                                   in_item.sat[i] ? CHAN_MAX : in_item.div[i].quo;
            default:            pixel_in[i*CHAN_W +: CHAN_W] = in_item.prem[i];
         endcase
      end
      if (alpha_zero) begin
         // transparent pixel: cleared when premultiplying, kept as is otherwise
         pixel_in = (in_item.mode == MODE_PREMULTIPLY) ? '0 : in_item.pixel;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

`default_nettype wire

// ===== design/alpha_premultiply_converter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Alpha premultiply converter: converts one 32-bit BGRA pixel per transfer
// (blue in bits 7:0, alpha in 31:24) between straight and premultiplied alpha.
// csr_write_data selects the mode: 0 multiplies each color by alpha and keeps
// the upper byte, with a zero-alpha pixel cleared to zero; 1 divides each color
// back as color*255/alpha, saturating at 255, and passes a zero-alpha pixel
// through unchanged. Alpha is always kept. The block takes one pixel every
// clock while rsp.ready stays high and passes each result in order through
// one stage for the products and dividends, four divider stages of two
// quotient bits each, and the output register. Every stage holds its item
// under back-pressure, so rsp.ready may drop at any time. Write the mode only
// while no pixel is in flight.
// depends on apc_pkg, apc_req_if, apc_rsp_if, apc_front, apc_div_stage, apc_pack

module alpha_premultiply_converter_unit (
   input  wire logic clock,
   input  wire logic reset,
   apc_req_if.sink   req,
   apc_rsp_if.source rsp,
   input  wire logic csr_write_enable,
   input  wire logic csr_write_data
);
   import apc_pkg::*;

   mode_type mode_ff, mode_in;

   logic     stage_valid [DIV_STAGES+1];
   logic     stage_ready [DIV_STAGES+1];
   item_type stage_item  [DIV_STAGES+1];

   assign mode_in = csr_write_enable ? mode_type'(csr_write_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PREMULTIPLY;
      end else begin
         mode_ff <= mode_in;
      end
   end

   apc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_pixel  (req.pixel_in),
      .in_mode   (mode_ff),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_item  (stage_item[0])
   );

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      apc_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_item   (stage_item[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_item  (stage_item[g+1])
      );
   end

   apc_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[DIV_STAGES]),
      .in_ready  (stage_ready[DIV_STAGES]),
      .in_item   (stage_item[DIV_STAGES]),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_pixel (rsp.pixel_out)
   );

endmodule

`default_nettype wire
